// ===== sv/qsao_pkg.sv =====
`timescale 1ns / 1ps
package qsao_pkg;

  localparam int NUM_BOXES    = 2;
  localparam int CORNERS      = 4;
  localparam int AXES_PER_BOX = 2;
  localparam int STORE_DEPTH  = NUM_BOXES * CORNERS;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int AXIS_W       = $clog2(NUM_BOXES * AXES_PER_BOX);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_P,
    ST_AX_Q,
    ST_AX_N,
    ST_PRJ_RD,
    ST_PRJ_MX,
    ST_PRJ_MY,
    ST_PRJ_ACC,
    ST_PRJ_UPD,
    ST_AX_TEST,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic mul_en;
    logic sel_y;
    logic acc_ld;
    logic acc_add;
  } mac_ctrl_t;

endpackage

// ===== sv/qsao_store.sv =====
`timescale 1ns / 1ps
module qsao_store #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [qsao_pkg::IDX_W-1:0]           wr_addr,
  input  logic [2*COORD_WIDTH-1:0]             wr_data,
  input  logic [qsao_pkg::IDX_W-1:0]           rd_addr,
  output logic [2*COORD_WIDTH-1:0]             rd_data
);
  import qsao_pkg::*;

  logic [2*COORD_WIDTH-1:0] mem [STORE_DEPTH];
  logic [2*COORD_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/qsao_mac.sv =====
`timescale 1ns / 1ps
module qsao_mac #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  qsao_pkg::mac_ctrl_t               ctrl,
  input  logic signed [COORD_WIDTH-1:0]     pt_x,
  input  logic signed [COORD_WIDTH-1:0]     pt_y,
  input  logic signed [COORD_WIDTH:0]       ax_nx,
  input  logic signed [COORD_WIDTH:0]       ax_ny,
  output logic signed [2*COORD_WIDTH+1:0]   proj
);
  import qsao_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] op_a;
  logic signed [COORD_WIDTH:0]   op_b;
  logic signed [PW-1:0]          prod_r;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [PW:0]            acc_r;
  logic signed [PW:0]            prod_ext;

  assign op_a     = ctrl.sel_y ? pt_y : pt_x;
  assign op_b     = ctrl.sel_y ? ax_ny : ax_nx;
  assign prod_nxt = op_a * op_b;
  assign prod_ext = {prod_r[PW-1], prod_r};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.acc_ld) begin
      acc_r <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign proj = acc_r;

endmodule

// ===== sv/quad_separating_axis_overlap.sv =====
`timescale 1ns / 1ps
// Separating-axis overlap test for two quadrilaterals.
// Input: a transaction is taken when start is high and busy is low. It writes
// one corner (in_which_box, in_corner, in_pos_x, in_pos_y) into an 8-entry
// corner store. A corner without in_check leaves busy low.
// With in_check set, the corner is stored and the test runs: for each of four
// axes (normals of edges 0-1 and 1-2 of each box) all eight corners are
// projected through one shared multiplier and accumulator, two multiplies
// per corner, and per-box min/max are kept. The test stops at the first
// separating axis, and it is paced by the single multiplier and the single
// store read port.
// Output: out_valid pulses for one cycle with out_overlap; the receiver must
// take it in that cycle, and busy falls the cycle after.
// Reset (rst_n low, synchronous) returns the sequencer to idle; the corner
// store is not cleared, and every corner must be loaded before a test.
module quad_separating_axis_overlap #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_which_box,
  input  logic [1:0]                    in_corner,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic                          in_check,
  output logic                          out_valid,
  output logic                          out_overlap
);
  import qsao_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PJ = 2 * COORD_WIDTH + 2;

  seq_state_t state_r, state_nxt;
  mac_ctrl_t  mac_ctrl;

  logic                  accept;
  logic [IDX_W-1:0]      rd_addr;
  logic [2*W-1:0]        rd_data;
  logic signed [W-1:0]   rd_x, rd_y;
  logic signed [W-1:0]   px_r, py_r;
  logic signed [W:0]     dx, dy;
  logic signed [W:0]     nx_r, ny_r;
  logic signed [PJ-1:0]  proj;
  logic signed [PJ-1:0]  mn_r [NUM_BOXES];
  logic signed [PJ-1:0]  mx_r [NUM_BOXES];
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [AXIS_W-1:0]     ax_r, ax_nxt;
  logic                  sep;
  logic                  last_j, last_ax;
  logic                  result_r, result_nxt;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  qsao_store #(.COORD_WIDTH(W)) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr ({in_which_box, in_corner}),
    .wr_data ({in_pos_x, in_pos_y}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[2*W-1:W];
  assign rd_y = rd_data[W-1:0];

  qsao_mac #(.COORD_WIDTH(W)) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .pt_x  (rd_x),
    .pt_y  (rd_y),
    .ax_nx (nx_r),
    .ax_ny (ny_r),
    .proj  (proj)
  );

  assign dx      = {px_r[W-1], px_r} - {rd_x[W-1], rd_x};
  assign dy      = {py_r[W-1], py_r} - {rd_y[W-1], rd_y};
  assign sep     = !((mn_r[0] <= mx_r[1]) && (mn_r[1] <= mx_r[0]));
  assign last_j  = (j_r == IDX_W'(STORE_DEPTH - 1));
  assign last_ax = (ax_r == AXIS_W'(NUM_BOXES * AXES_PER_BOX - 1));

  // edge p->q: p = box*4 + i, q = box*4 + i + 1, i in {0, 1}
  always_comb begin
    case (state_r)
      ST_AX_P: rd_addr = {ax_r[1], 1'b0, ax_r[0]};
      ST_AX_Q: rd_addr = {ax_r[1], ax_r[0], ~ax_r[0]};
      default: rd_addr = j_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept && in_check) state_nxt = ST_AX_P;
      ST_AX_P:    state_nxt = ST_AX_Q;
      ST_AX_Q:    state_nxt = ST_AX_N;
      ST_AX_N:    state_nxt = ST_PRJ_RD;
      ST_PRJ_RD:  state_nxt = ST_PRJ_MX;
      ST_PRJ_MX:  state_nxt = ST_PRJ_MY;
      ST_PRJ_MY:  state_nxt = ST_PRJ_ACC;
      ST_PRJ_ACC: state_nxt = ST_PRJ_UPD;
      ST_PRJ_UPD: state_nxt = last_j ? ST_AX_TEST : ST_PRJ_RD;
      ST_AX_TEST: state_nxt = (sep || last_ax) ? ST_DONE : ST_AX_P;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctrl   = '0;
    j_nxt      = j_r;
    ax_nxt     = ax_r;
    result_nxt = result_r;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ax_nxt = '0;
      end
      ST_AX_N: begin
        j_nxt = '0;
      end
      ST_PRJ_MX: begin
        mac_ctrl.mul_en = 1'b1;
      end
      ST_PRJ_MY: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sel_y  = 1'b1;
        mac_ctrl.acc_ld = 1'b1;
      end
      ST_PRJ_ACC: begin
        mac_ctrl.acc_add = 1'b1;
      end
      ST_PRJ_UPD: begin
        j_nxt = j_r + 1'b1;
      end
      ST_AX_TEST: begin
        ax_nxt     = ax_r + 1'b1;
        result_nxt = !sep;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_overlap = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    ax_r     <= ax_nxt;
    result_r <= result_nxt;
    if (state_r == ST_AX_Q) begin
      px_r <= rd_x;
      py_r <= rd_y;
    end
    if (state_r == ST_AX_N) begin
      if (dy == '0) begin
        nx_r <= '0;
        ny_r <= (W+1)'(1);
      end else begin
        nx_r <= -dy;
        ny_r <= dx;
      end
    end
    if (state_r == ST_PRJ_UPD) begin
      if (j_r[1:0] == 2'b00) begin
        mn_r[j_r[2]] <= proj;
        mx_r[j_r[2]] <= proj;
      end else begin
        if (proj < mn_r[j_r[2]]) mn_r[j_r[2]] <= proj;
        if (proj > mx_r[j_r[2]]) mx_r[j_r[2]] <= proj;
      end
    end
  end

endmodule
